[rtl/teb_pkg.sv]
// Shared types and constants of the truncated exponential backoff unit.
`default_nettype none

package teb_pkg;

	// Field widths
	localparam int SLOT_W  = 16;
	localparam int TIME_W  = 32;
	localparam int EXP_W   = 5;
	localparam int OP_W    = 2;
	localparam int FRAC_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Fractional bits of random_fraction
	localparam int RAND_BITS = 16;

	// Hard cap on the exponent
	localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(16);

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_INCR  = 2'd1;
	localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_TIME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SLOTS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOTS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_CEIL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 3'd4;

	// Register reset values
	localparam logic [SLOT_W-1:0] RST_SLOT_TIME   = 16'd1000;
	localparam logic [SLOT_W-1:0] RST_MIN_SLOTS   = 16'd1;
	localparam logic [SLOT_W-1:0] RST_MAX_SLOTS   = 16'd1000;
	localparam logic [EXP_W-1:0]  RST_EXP_CEIL    = 5'd10;
	localparam logic [SLOT_W-1:0] RST_RETRY_LIMIT = 16'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_RESULT
	} state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic accept;  // take request, update retries, set up window
		logic scale;   // window span times fraction
		logic load;    // form slots and time, fill output register
	} cmd_t;

endpackage

`default_nettype wire

[rtl/teb_ctrl.sv]
// Sequencer of the backoff unit: handshakes and datapath commands.
`default_nettype none

module teb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output teb_pkg::cmd_t      cmd
);

	teb_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= teb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			teb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = teb_pkg::ST_SCALE;
				end
			end
			teb_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = teb_pkg::ST_RESULT;
			end
			teb_pkg::ST_RESULT: begin
				// next request may enter as this result leaves
				if (out_free) begin
					cmd.load = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = teb_pkg::ST_SCALE;
					end else begin
						state_d = teb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = teb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_load_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == teb_pkg::ST_RESULT) && out_free)
		else $error("load outside result state or into full output");

	a_accept_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == teb_pkg::ST_SCALE))
		else $error("accepted request not followed by scale");

	a_scale_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == teb_pkg::ST_SCALE) |=> (state_q == teb_pkg::ST_RESULT))
		else $error("scale not followed by result");

	a_scale_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |-> !cmd.accept && !cmd.load)
		else $error("scale overlaps accept or load");

endmodule

`default_nettype wire

[rtl/teb_datapath.sv]
// Backoff datapath: registers, retry counter, window, scaling and time.
`default_nettype none

module teb_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire teb_pkg::cmd_t                     cmd,
	input  wire logic                              cfg_we,
	input  wire logic [teb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [teb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [teb_pkg::OP_W-1:0]          operation,
	input  wire logic [teb_pkg::FRAC_W-1:0]        random_fraction,
	output logic      [teb_pkg::SLOT_W-1:0]        backoff_slots,
	output logic      [teb_pkg::TIME_W-1:0]        backoff_time,
	output logic      [teb_pkg::SLOT_W-1:0]        retry_count,
	output logic                                   limit_reached
);

	localparam int SW = teb_pkg::SLOT_W;
	localparam int PW = teb_pkg::SLOT_W + teb_pkg::FRAC_W;

	logic [SW-1:0]             slot_time_q, min_slots_q, max_slots_q, retry_limit_q;
	logic [teb_pkg::EXP_W-1:0] exp_ceil_q;
	logic [SW-1:0]             retries_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_time_q   <= teb_pkg::RST_SLOT_TIME;
			min_slots_q   <= teb_pkg::RST_MIN_SLOTS;
			max_slots_q   <= teb_pkg::RST_MAX_SLOTS;
			exp_ceil_q    <= teb_pkg::RST_EXP_CEIL;
			retry_limit_q <= teb_pkg::RST_RETRY_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				teb_pkg::REG_SLOT_TIME:   slot_time_q   <= cfg_data[SW-1:0];
				teb_pkg::REG_MIN_SLOTS:   min_slots_q   <= cfg_data[SW-1:0];
				teb_pkg::REG_MAX_SLOTS:   max_slots_q   <= cfg_data[SW-1:0];
				teb_pkg::REG_EXP_CEIL:    exp_ceil_q    <= cfg_data[teb_pkg::EXP_W-1:0];
				teb_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	// retry counter, updated as the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retries_q <= '0;
		end else if (cmd.accept) begin
			case (operation)
				teb_pkg::OP_CLEAR: retries_q <= '0;
				teb_pkg::OP_INCR: begin
					if (retries_q != {SW{1'b1}}) begin
						retries_q <= retries_q + SW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// window from the current count (a draw leaves it unchanged)
	logic [SW-1:0]             ceil_ext, exp_wide;
	logic [teb_pkg::EXP_W-1:0] expo;
	logic [SW-1:0]             upper_raw, upper;
	logic                      empty;
	logic [SW-1:0]             span;

	always_comb begin
		ceil_ext  = SW'(exp_ceil_q);
		exp_wide  = ((exp_ceil_q != '0) && (retries_q > ceil_ext)) ? ceil_ext : retries_q;
		expo      = (exp_wide > SW'(teb_pkg::EXP_MAX)) ? teb_pkg::EXP_MAX
		                                               : exp_wide[teb_pkg::EXP_W-1:0];
		upper_raw = ~({SW{1'b1}} << expo);   // 2^expo - 1, all ones at 16
		upper     = (upper_raw > max_slots_q) ? max_slots_q : upper_raw;
		empty     = (upper <= min_slots_q);
		span      = upper - min_slots_q;
	end

	logic                 draw_s1, empty_s1;
	logic [SW-1:0]        span_s1;
	logic [teb_pkg::FRAC_W-1:0] frac_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			draw_s1  <= (operation == teb_pkg::OP_DRAW);
			empty_s1 <= empty;
			span_s1  <= span;
			frac_s1  <= random_fraction;
		end
	end

	logic          draw_s2, empty_s2;
	logic [SW-1:0] span_s2;
	logic [PW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			draw_s2  <= draw_s1;
			empty_s2 <= empty_s1;
			span_s2  <= span_s1;
			prod_s2  <= PW'(span_s1) * PW'(frac_s1);
		end
	end

	// offset, clamped to the span for oversized fractions
	logic [PW-1:0]                off_full;
	logic [SW-1:0]                off_sat;
	logic [SW-1:0]                slots_d;
	logic [teb_pkg::TIME_W-1:0]   time_d;

	always_comb begin
		off_full = prod_s2 >> teb_pkg::RAND_BITS;
		off_sat  = (off_full > PW'(span_s2)) ? span_s2 : off_full[SW-1:0];
		if (!draw_s2) begin
			slots_d = '0;
		end else if (empty_s2) begin
			slots_d = min_slots_q;
		end else begin
			slots_d = min_slots_q + off_sat;
		end
		time_d = teb_pkg::TIME_W'(slots_d) * teb_pkg::TIME_W'(slot_time_q);
	end

	logic [SW-1:0]              slots_q, count_q;
	logic [teb_pkg::TIME_W-1:0] time_q;
	logic                       limit_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slots_q <= slots_d;
			time_q  <= time_d;
			count_q <= retries_q;
			limit_q <= (retries_q >= retry_limit_q);
		end
	end

	assign backoff_slots = slots_q;
	assign backoff_time  = time_q;
	assign retry_count   = count_q;
	assign limit_reached = limit_q;

endmodule

`default_nettype wire

[rtl/truncated_exponential_backoff_unit.sv]
// Top level of the truncated binary exponential backoff unit.
`default_nettype none

// Keeps a 16-bit retry counter and serves one request at a time: clear it,
// increment it (saturating at 65535), or draw a backoff whose window top is
// min(2^e - 1, max_slots), with e the count capped at exponent_ceiling (when
// nonzero) and at 16. Each request gives exactly one result carrying the slot
// count, slot count times slot_time, the count after the request and the limit
// flag. A request passes the s1 registers, the s2 product register and the
// output register: the span-times-fraction multiply is registered in the scale
// step; the offset add and slot-time multiply feed the output register in the
// result step, where the next request may already be taken. The output register
// holds a result until taken; while it is full, a result waits in the result
// step and no request is taken there. Configuration writes land at once and are
// meant for idle periods only. Non-draw requests report zero slots and zero time.

module truncated_exponential_backoff_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [teb_pkg::OP_W-1:0]          operation,
	input  wire logic [teb_pkg::FRAC_W-1:0]        random_fraction,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [teb_pkg::SLOT_W-1:0]        backoff_slots,
	output logic      [teb_pkg::TIME_W-1:0]        backoff_time,
	output logic      [teb_pkg::SLOT_W-1:0]        retry_count,
	output logic                                   limit_reached,
	// register write port
	input  wire logic                              cfg_we,
	input  wire logic [teb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [teb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	teb_pkg::cmd_t cmd;

	// sequencer: accept, scale, load
	teb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// counter, window math, multiplies and output register
	teb_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.random_fraction (random_fraction),
		.backoff_slots   (backoff_slots),
		.backoff_time    (backoff_time),
		.retry_count     (retry_count),
		.limit_reached   (limit_reached)
	);

endmodule

`default_nettype wire
